// ===== design/slbs_pkg.sv =====
// ----------------------------------------------------------------------------
// slbs_pkg
// Shared types, codes and constants of the status LED blink sequencer.
// ----------------------------------------------------------------------------
package slbs_pkg;

	// blink palette size, up to three colors
	localparam int BLINK_COLOR_COUNT_DEF = 3;
	localparam int PALETTE_SIZE          = 3;

	// command codes
	typedef enum logic [1:0] {
		OP_SET_MODE = 2'd0,
		OP_BLINK    = 2'd1,
		OP_TICK     = 2'd2
	} op_t;

	// pixel modes, blinking included
	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_WORK  = 2'd1,
		MODE_BREAK = 2'd2,
		MODE_BLINK = 2'd3
	} mode_t;

	// configuration register indexes
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;
	localparam logic [CFG_INDEX_W-1:0] REG_IDLE_COLOR  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WORK_COLOR  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BREAK_COLOR = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_REFRESH_MS  = 3'd4;

	// reset values of the registers
	localparam logic [23:0] IDLE_COLOR_RST  = 24'h000000;
	localparam logic [23:0] WORK_COLOR_RST  = 24'h804000;
	localparam logic [23:0] BREAK_COLOR_RST = 24'h000080;
	localparam logic [7:0]  BRIGHTNESS_RST  = 8'd50;
	localparam logic [15:0] REFRESH_MS_RST  = 16'd50;
	localparam logic [7:0]  BLINK_BRIGHTNESS = 8'd255;

	// blue, deep pink, orange
	localparam logic [23:0] BLINK_PALETTE [PALETTE_SIZE] = '{
		24'h0000FF, 24'hFF1493, 24'hFFA500
	};

	// one input item
	typedef struct packed {
		logic [1:0]  opcode;
		logic [1:0]  new_mode;
		logic [15:0] sweep_count;
		logic [15:0] phase_ms;
		logic [31:0] now_ms;
	} item_t;

	// color and timing settings seen by the step logic
	typedef struct packed {
		logic [23:0] idle_color;
		logic [23:0] work_color;
		logic [23:0] break_color;
		logic [15:0] refresh_interval;
	} cfg_t;

	// sequencer state
	typedef struct packed {
		mode_t       mode;
		mode_t       saved_mode;
		logic [31:0] last_refresh;
		logic [31:0] next_change;
		logic [15:0] phase_len;
		logic [15:0] sweeps_target;
		logic [15:0] sweeps_done;
		logic [1:0]  color_idx;
		logic        on_phase;
		logic [23:0] pixel;
		logic [7:0]  saved_bright;
		logic [7:0]  active_bright;
	} state_t;

	localparam state_t STATE_RST = '{
		mode:          MODE_IDLE,
		saved_mode:    MODE_IDLE,
		last_refresh:  32'd0,
		next_change:   32'd0,
		phase_len:     16'd0,
		sweeps_target: 16'd0,
		sweeps_done:   16'd0,
		color_idx:     2'd0,
		on_phase:      1'b0,
		pixel:         24'd0,
		saved_bright:  BRIGHTNESS_RST,
		active_bright: BRIGHTNESS_RST
	};

	// one result item
	typedef struct packed {
		logic [23:0] pixel;
		logic [7:0]  brightness;
		logic        refresh;
		mode_t       mode;
	} result_t;

	// palette lookup, out-of-range index falls back to the first color
	function automatic logic [23:0] palette_at(logic [1:0] idx, int count);
		logic [23:0] col;
		col = BLINK_PALETTE[0];
		if (32'(idx) < count && 32'(idx) < PALETTE_SIZE) begin
			col = BLINK_PALETTE[idx];
		end
		return col;
	endfunction

endpackage

// ===== design/slbs_step.sv =====
// ----------------------------------------------------------------------------
// slbs_step
// Next-state and result logic for one command against the current state.
// ----------------------------------------------------------------------------
module slbs_step
	import slbs_pkg::*;
#(
	parameter int BLINK_COLOR_COUNT = BLINK_COLOR_COUNT_DEF
) (
	input  item_t  item,
	input  cfg_t   cfg,
	input  state_t cur,
	output state_t nxt,
	output logic   refresh
);

	logic [31:0] elapsed;
	logic [1:0]  idx_inc;
	logic        idx_wrap;
	logic [15:0] sweeps_new;

	assign elapsed    = item.now_ms - cur.last_refresh;
	assign idx_inc    = cur.color_idx + 2'd1;
	assign idx_wrap   = 32'(idx_inc) >= BLINK_COLOR_COUNT;
	assign sweeps_new = idx_wrap ? cur.sweeps_done + 16'd1 : cur.sweeps_done;

	// command decode and state update
	always_comb begin
		nxt     = cur;
		refresh = 1'b0;
		unique case (item.opcode)
			OP_SET_MODE: begin
				if (mode_t'(item.new_mode) != MODE_BLINK) begin
					if (cur.mode == MODE_BLINK) begin
						nxt.active_bright = cur.saved_bright;
					end
					nxt.mode = mode_t'(item.new_mode);
				end
			end
			OP_BLINK: begin
				if (cur.mode != MODE_BLINK) begin
					nxt.saved_mode   = cur.mode;
					nxt.saved_bright = cur.active_bright;
				end
				nxt.mode          = MODE_BLINK;
				nxt.sweeps_target = item.sweep_count;
				nxt.sweeps_done   = 16'd0;
				nxt.color_idx     = 2'd0;
				nxt.on_phase      = 1'b1;
				nxt.phase_len     = item.phase_ms;
				nxt.next_change   = item.now_ms + {16'd0, item.phase_ms};
				nxt.active_bright = BLINK_BRIGHTNESS;
				nxt.pixel         = palette_at(2'd0, BLINK_COLOR_COUNT);
			end
			OP_TICK: begin
				if (cur.mode == MODE_BLINK || elapsed >= {16'd0, cfg.refresh_interval}) begin
					refresh = 1'b1;
					// blink phase step once the deadline is reached
					if (cur.mode == MODE_BLINK && item.now_ms >= cur.next_change) begin
						nxt.next_change = item.now_ms + {16'd0, cur.phase_len};
						if (cur.on_phase) begin
							nxt.pixel    = 24'd0;
							nxt.on_phase = 1'b0;
						end else begin
							nxt.color_idx   = idx_wrap ? 2'd0 : idx_inc;
							nxt.sweeps_done = sweeps_new;
							if (sweeps_new >= cur.sweeps_target) begin
								nxt.active_bright = cur.saved_bright;
								nxt.mode          = cur.saved_mode;
							end else begin
								nxt.pixel    = palette_at(nxt.color_idx, BLINK_COLOR_COUNT);
								nxt.on_phase = 1'b1;
							end
						end
					end
					// steady refresh
					if (nxt.mode != MODE_BLINK) begin
						nxt.last_refresh = item.now_ms;
						nxt.saved_mode   = nxt.mode;
						case (nxt.mode)
							MODE_WORK:  nxt.pixel = cfg.work_color;
							MODE_BREAK: nxt.pixel = cfg.break_color;
							default:    nxt.pixel = cfg.idle_color;
						endcase
					end
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

// ===== design/status_led_blink_sequencer.sv =====
// A transferred command waits in the input stage; its result is registered in the result stage when it advances.
// Throughput: one command per cycle; the single-pass step logic between the input
// stage and the result register sets this figure, and output stall holds both stages.
// Reset: asynchronous, active low; clears both valid flags, the sequencer state
// (idle mode, black pixel, brightness 50) and the settings to their defaults.
// ----------------------------------------------------------------------------
// status_led_blink_sequencer
// RGB status pixel sequencer: steady modes, blink sweeps and timed refresh.
// ----------------------------------------------------------------------------
module status_led_blink_sequencer
	import slbs_pkg::*;
#(
	parameter int BLINK_COLOR_COUNT = BLINK_COLOR_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// settings write port
	input  logic                   wr_en,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  logic [CFG_DATA_W-1:0]  wr_data,
	// command channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             opcode,
	input  logic [1:0]             new_mode,
	input  logic [15:0]            sweep_count,
	input  logic [15:0]            phase_ms,
	input  logic [31:0]            now_ms,
	// result channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             red,
	output logic [7:0]             green,
	output logic [7:0]             blue,
	output logic [7:0]             brightness,
	output logic                   refresh,
	output logic [1:0]             mode
);

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t res_s2;
	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	logic    step_refresh;
	logic    advance;
	logic    in_xfer;

	// handshake
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= '{opcode: opcode, new_mode: new_mode, sweep_count: sweep_count,
				phase_ms: phase_ms, now_ms: now_ms};
		end
	end

	// step logic
	slbs_step #(
		.BLINK_COLOR_COUNT(BLINK_COLOR_COUNT)
	) u_step (
		.item    (item_s1),
		.cfg     (cfg_q),
		.cur     (state_q),
		.nxt     (state_nxt),
		.refresh (step_refresh)
	);

	// settings registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{idle_color: IDLE_COLOR_RST, work_color: WORK_COLOR_RST,
				break_color: BREAK_COLOR_RST, refresh_interval: REFRESH_MS_RST};
		end else if (wr_en) begin
			case (wr_index)
				REG_IDLE_COLOR:  cfg_q.idle_color       <= wr_data;
				REG_WORK_COLOR:  cfg_q.work_color       <= wr_data;
				REG_BREAK_COLOR: cfg_q.break_color      <= wr_data;
				REG_REFRESH_MS:  cfg_q.refresh_interval <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	// sequencer state, brightness write applies at once outside blinking when no command advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RST;
		end else if (advance) begin
			state_q <= state_nxt;
		end else if (wr_en && wr_index == REG_BRIGHTNESS && state_q.mode != MODE_BLINK) begin
			state_q.active_bright <= wr_data[7:0];
		end
	end

	// result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// result stage payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= '{pixel: state_nxt.pixel, brightness: state_nxt.active_bright,
				refresh: step_refresh, mode: state_nxt.mode};
		end
	end

	// result ports
	assign out_valid  = valid_s2;
	assign red        = res_s2.pixel[23:16];
	assign green      = res_s2.pixel[15:8];
	assign blue       = res_s2.pixel[7:0];
	assign brightness = res_s2.brightness;
	assign refresh    = res_s2.refresh;
	assign mode       = res_s2.mode;

endmodule

// ===== design/slbs_checker.sv =====
// ----------------------------------------------------------------------------
// slbs_checker
// Port-level checks of the status LED blink sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module slbs_checker
	import slbs_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic [7:0] brightness,
	input logic [1:0] mode
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its color
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(red) && $stable(green) && $stable(blue))
		else $error("stalled result changed");

	// blinking always runs at full brightness
	a_blink_bright: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode == MODE_BLINK |-> brightness == BLINK_BRIGHTNESS)
		else $error("blink result without full brightness");

	// while blinking the pixel is dark or a palette color
	a_blink_color: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode == MODE_BLINK |->
			(red == 8'h00 && green == 8'h00 && blue == 8'h00) ||
			(red == 8'h00 && green == 8'h00 && blue == 8'hFF) ||
			(red == 8'hFF && green == 8'h14 && blue == 8'h93) ||
			(red == 8'hFF && green == 8'hA5 && blue == 8'h00))
		else $error("blink result with a color outside the palette");

endmodule

bind status_led_blink_sequencer slbs_checker u_slbs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.red        (red),
	.green      (green),
	.blue       (blue),
	.brightness (brightness),
	.mode       (mode)
);
